// ===== rtl/core/mpqs_pkg.sv =====
// Shared types and constants for the unsorted-array minimum priority queue.
package mpqs_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic [OCC_W-1:0]         occupancy;
    } out_t;

endpackage

// ===== rtl/core/mpqs_store.sv =====
// Entry store: simple dual-port memory, one write and one registered read per cycle.
module mpqs_store #(
    parameter int DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  logic signed [mpqs_pkg::DATA_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic signed [mpqs_pkg::DATA_W-1:0] rd_data
);
    import mpqs_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/min_priority_queue_scan.sv =====
// Bounded minimum priority queue, kept as an unsorted array in one dual-port memory.
// An insert writes straight to the memory; its result is registered and handed from the
// emit state to the output register, at which point the next request can already be
// taken; overflow and underflow take the same path. A remove scans the stored entries
// for the smallest with one memory read per cycle (earliest wins on a tie), then moves
// the later entries down one place, one read and one write per cycle, and then emits
// its result through the same emit state. One request is in progress at a time; a
// finished result waits in the output register while the next request is taken, and a
// result still waiting there when the next one is ready holds the block until the
// output is taken.
module min_priority_queue_scan #(
    parameter int CAPACITY = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mpqs_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mpqs_pkg::out_t out_data
);
    import mpqs_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            scan_idx_reg, scan_idx_next;
    logic [AW-1:0]            sh_idx_reg, sh_idx_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    out_t                     res_reg, res_next;
    out_t                     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic signed [DATA_W-1:0] wr_data, rd_data;

    logic                     cand_better;
    logic [AW-1:0]            cand_idx;
    logic signed [DATA_W-1:0] cand_val;
    logic [CW-1:0]            count_dec;

    mpqs_store #(
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign count_dec   = count_reg - CW'(1);
    // first scanned entry always wins; later ones only when strictly smaller
    assign cand_better = (scan_idx_reg == '0) || (rd_data < best_val_reg);
    assign cand_idx    = cand_better ? scan_idx_reg : best_idx_reg;
    assign cand_val    = cand_better ? rd_data : best_val_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        sh_idx_next    = sh_idx_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = sh_idx_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next.removed_value = '0;
                    res_next.occupancy     = OCC_W'(count_reg);
                    state_next             = S_EMIT;
                    if (in_data.action == ACT_INSERT)
                    begin
                        if (XW'(count_reg) >= XW'(CAPACITY))
                        begin
                            res_next.status = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            wr_en              = 1'b1;
                            wr_addr            = count_reg[AW-1:0];
                            wr_data            = in_data.value;
                            count_next         = count_reg + CW'(1);
                            res_next.status    = STATUS_OK;
                            res_next.occupancy = OCC_W'(count_reg + CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                best_idx_next          = cand_idx;
                best_val_next          = cand_val;
                res_next.status        = STATUS_OK;
                res_next.removed_value = cand_val;
                if (XW'(scan_idx_reg) + XW'(1) < XW'(count_reg))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg + AW'(1);
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
                else if (XW'(cand_idx) + XW'(1) < XW'(count_reg))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = AW'(XW'(cand_idx) + XW'(1));
                    sh_idx_next = cand_idx;
                    state_next  = S_SHIFT;
                end
                else
                begin
                    count_next         = count_dec;
                    res_next.occupancy = OCC_W'(count_dec);
                    state_next         = S_EMIT;
                end
            end

            S_SHIFT:
            begin
                // entry sh_idx+1 arrives now and drops into sh_idx
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg;
                wr_data = rd_data;
                if (XW'(sh_idx_reg) + XW'(2) < XW'(count_reg))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = AW'(XW'(sh_idx_reg) + XW'(2));
                    sh_idx_next = sh_idx_reg + AW'(1);
                end
                else
                begin
                    count_next         = count_dec;
                    res_next.occupancy = OCC_W'(count_dec);
                    state_next         = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        sh_idx_reg   <= sh_idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (XW'(scan_idx_reg) < XW'(count_reg)))
        else $error("scan read beyond occupied entries");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (XW'(sh_idx_reg) + XW'(1) < XW'(count_reg)))
        else $error("shift beyond occupied entries");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != STATUS_OK)) |-> (out_reg.removed_value == '0))
        else $error("failed request carries a removed value");

endmodule
